// ===== rtl/axi4_slave_burst_request_bridge_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the AXI4 slave burst request bridge
// Clocked wrappers used by the bridge checker.
// ---------------------------------------------------------------------------
`ifndef AXI4_SLAVE_BURST_REQUEST_BRIDGE_MACROS_SVH
`define AXI4_SLAVE_BURST_REQUEST_BRIDGE_MACROS_SVH

// Property checked outside reset
`define ASBRB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every edge, reset included
`define ASBRB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/asbrb_pkg.sv =====
// ---------------------------------------------------------------------------
// asbrb_pkg
// Types, bit positions and helpers shared by the burst request bridge.
// ---------------------------------------------------------------------------
package asbrb_pkg;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_W          = 4'd1,
        ST_BURST_W    = 4'd2,
        ST_LAST_W     = 4'd3,
        ST_B          = 4'd4,
        ST_ADDR_R     = 4'd5,
        ST_ADDRDATA_R = 4'd6,
        ST_DATA_R     = 4'd7,
        ST_OUT_R      = 4'd8
    } t_state;

    localparam int PAGE_BITS = 12;
    localparam logic [PAGE_BITS-1:0] PAGE_MASK = 12'hFFF;
    localparam int FLAG_BITS = 10;

    // AXI burst codes (reserved code behaves as incrementing)
    localparam logic [1:0] BURST_FIXED = 2'd0;
    localparam logic [1:0] BURST_INCR  = 2'd1;
    localparam logic [1:0] BURST_WRAP  = 2'd2;

    // Bit positions in the handshake word of a request
    localparam int HS_AW_VALID   = 0;
    localparam int HS_W_VALID    = 1;
    localparam int HS_AR_VALID   = 2;
    localparam int HS_B_READY    = 3;
    localparam int HS_R_READY    = 4;
    localparam int HS_REQ_READY  = 5;
    localparam int HS_RESP_VALID = 6;
    localparam int HS_RESP_ERR   = 7;

    // Bit positions in the flag word of a result
    localparam int FL_REQ_VALID = 0;
    localparam int FL_REQ_WRITE = 1;
    localparam int FL_REQ_LAST  = 2;
    localparam int FL_AW_READY  = 3;
    localparam int FL_W_READY   = 4;
    localparam int FL_AR_READY  = 5;
    localparam int FL_B_VALID   = 6;
    localparam int FL_R_VALID   = 7;
    localparam int FL_R_LAST    = 8;
    localparam int FL_RESP_ERR  = 9;

    // Burst stepping controls handed to the address stepper
    typedef struct packed {
        logic [1:0]           kind;
        logic [PAGE_BITS-1:0] wrap_mask;
        logic [7:0]           beat_bytes;
    } t_burst_ctl;

    // Wrap mask: bytes * beats - 1, saturated to the page
    function automatic logic [PAGE_BITS-1:0] wrap_mask_of(input logic [2:0] size,
                                                          input logic [7:0] len);
        logic [15:0] total;
        total = ({8'd0, len} + 16'd1) << size;
        if (total > 16'd4096) begin
            return PAGE_MASK;
        end
        return PAGE_BITS'(total - 16'd1);
    endfunction

endpackage

// ===== rtl/asbrb_if.sv =====
// ---------------------------------------------------------------------------
// asbrb_in_if / asbrb_out_if
// Valid/ready channels carrying one bus cycle in and one status word out.
// ---------------------------------------------------------------------------
interface asbrb_in_if
    import asbrb_pkg::*;
#(
    parameter int ADDR_BITS = 48,
    parameter int DATA_BITS = 64,
    parameter int ID_BITS   = 5,
    parameter int USER_BITS = 1
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             handshakes;
    logic [ADDR_BITS-1:0]   ax_address;
    logic [2:0]             ax_size;
    logic [7:0]             ax_length;
    logic [1:0]             ax_burst;
    logic [ID_BITS-1:0]     ax_ident;
    logic [USER_BITS-1:0]   ax_userbits;
    logic [DATA_BITS-1:0]   write_data;
    logic [DATA_BITS/8-1:0] write_strobe;
    logic [DATA_BITS-1:0]   read_data_in;

    modport source (
        output valid, handshakes, ax_address, ax_size, ax_length, ax_burst,
               ax_ident, ax_userbits, write_data, write_strobe, read_data_in,
        input  ready
    );
    modport sink (
        input  valid, handshakes, ax_address, ax_size, ax_length, ax_burst,
               ax_ident, ax_userbits, write_data, write_strobe, read_data_in,
        output ready
    );
endinterface

interface asbrb_out_if
    import asbrb_pkg::*;
#(
    parameter int ADDR_BITS = 48,
    parameter int DATA_BITS = 64,
    parameter int ID_BITS   = 5,
    parameter int USER_BITS = 1
);
    logic                   valid;
    logic                   ready;
    logic [FLAG_BITS-1:0]   flags;
    logic [ADDR_BITS-1:0]   request_address;
    logic [7:0]             request_size;
    logic [DATA_BITS-1:0]   request_wdata;
    logic [DATA_BITS/8-1:0] request_wstrb;
    logic [DATA_BITS-1:0]   read_data_out;
    logic [ID_BITS-1:0]     resp_ident;
    logic [USER_BITS-1:0]   resp_userbits;

    modport source (
        output valid, flags, request_address, request_size, request_wdata,
               request_wstrb, read_data_out, resp_ident, resp_userbits,
        input  ready
    );
    modport sink (
        input  valid, flags, request_address, request_size, request_wdata,
               request_wstrb, read_data_out, resp_ident, resp_userbits,
        output ready
    );
endinterface

// ===== rtl/asbrb_beat_addr.sv =====
// ---------------------------------------------------------------------------
// asbrb_beat_addr
// Next beat address for fixed, incrementing and wrapping bursts, kept
// inside the current 4 KB page.
// ---------------------------------------------------------------------------
module asbrb_beat_addr
    import asbrb_pkg::*;
#(
    parameter int ADDR_BITS = 48
) (
    input  logic [ADDR_BITS-1:0] i_addr,
    input  t_burst_ctl           i_ctl,
    output logic [ADDR_BITS-1:0] o_next
);

    logic [PAGE_BITS-1:0] w_lo;
    logic [PAGE_BITS-1:0] w_inc;
    logic [PAGE_BITS-1:0] w_nxt;

    // Step the page offset; carries out of the page are dropped
    assign w_lo  = i_addr[PAGE_BITS-1:0];
    assign w_inc = w_lo + {{(PAGE_BITS-8){1'b0}}, i_ctl.beat_bytes};

    // Select by burst kind
    always_comb begin
        unique case (i_ctl.kind)
            BURST_FIXED: w_nxt = w_lo;
            BURST_WRAP:  w_nxt = (w_lo & ~i_ctl.wrap_mask) | (w_inc & i_ctl.wrap_mask);
            default:     w_nxt = w_inc;
        endcase
    end

    // Hold the page bits
    assign o_next = {i_addr[ADDR_BITS-1:PAGE_BITS], w_nxt};

endmodule

// ===== rtl/axi4_slave_burst_request_bridge.sv =====
// ---------------------------------------------------------------------------
// axi4_slave_burst_request_bridge
// AXI4 slave controller that splits read and write bursts into one
// downstream request per beat.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one cycle of the AXI and downstream signals per request:
//   the handshake word (valids, readies, downstream error), the AW/AR
//   fields, the W beat and the downstream read data. o_out returns one
//   status word per request: flags, downstream beat address, size, write
//   data and strobes, R data, echoed id and user bits.
//   Each accepted request produces exactly one result, registered in the next
//   cycle; the controller advances once per accepted request. A new
//   request is taken every cycle while the result register is free or being
//   drained, so the throughput is one per clock unless o_out stalls.
//   Writes win over reads in idle. Addresses step within their 4 KB page.
//   Reset (synchronous, active low) returns the controller to idle with all
//   burst registers cleared and drops the result valid.
//   When the receiver stalls o_out, the result holds and i_in.ready falls
//   until it is taken.
// ---------------------------------------------------------------------------
module axi4_slave_burst_request_bridge
    import asbrb_pkg::*;
#(
    parameter int ADDR_BITS = 48,
    parameter int DATA_BITS = 64,
    parameter int ID_BITS   = 5,
    parameter int USER_BITS = 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    asbrb_in_if.sink   i_in,
    asbrb_out_if.source o_out
);

    localparam int STRB_BITS = DATA_BITS / 8;

    // Controller and burst registers
    t_state               r_state,      n_state;
    logic                 r_dn_valid,   n_dn_valid;
    logic                 r_dn_write,   n_dn_write;
    logic [ADDR_BITS-1:0] r_beat_addr,  n_beat_addr;
    logic [DATA_BITS-1:0] r_wdata,      n_wdata;
    logic [STRB_BITS-1:0] r_wstrb,      n_wstrb;
    logic [7:0]           r_beat_bytes, n_beat_bytes;
    logic [7:0]           r_beats_left, n_beats_left;
    logic [1:0]           r_burst_kind, n_burst_kind;
    logic [PAGE_BITS-1:0] r_wrap_mask,  n_wrap_mask;
    logic [ID_BITS-1:0]   r_id,         n_id;
    logic [USER_BITS-1:0] r_user,       n_user;
    logic                 r_rvalid,     n_rvalid;
    logic                 r_rlast,      n_rlast;
    logic [DATA_BITS-1:0] r_rdata,      n_rdata;
    logic                 r_err,        n_err;

    // Result register
    logic                 r_out_valid;
    logic [FLAG_BITS-1:0] r_out_flags;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [7:0]           r_out_size;
    logic [DATA_BITS-1:0] r_out_wdata;
    logic [STRB_BITS-1:0] r_out_wstrb;
    logic [DATA_BITS-1:0] r_out_rdata;
    logic [ID_BITS-1:0]   r_out_id;
    logic [USER_BITS-1:0] r_out_user;

    logic                 w_accept;
    logic                 w_aw_valid, w_w_valid, w_ar_valid, w_b_ready;
    logic                 w_r_ready, w_req_ready, w_resp_valid, w_resp_err;
    logic                 w_aw_ready, w_w_ready, w_ar_ready, w_b_valid;
    logic [FLAG_BITS-1:0] w_flags;
    logic [ADDR_BITS-1:0] w_next_addr;
    t_burst_ctl           w_ctl;

    // Take a request whenever the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Unpack the handshake word
    assign w_aw_valid   = i_in.handshakes[HS_AW_VALID];
    assign w_w_valid    = i_in.handshakes[HS_W_VALID];
    assign w_ar_valid   = i_in.handshakes[HS_AR_VALID];
    assign w_b_ready    = i_in.handshakes[HS_B_READY];
    assign w_r_ready    = i_in.handshakes[HS_R_READY];
    assign w_req_ready  = i_in.handshakes[HS_REQ_READY];
    assign w_resp_valid = i_in.handshakes[HS_RESP_VALID];
    assign w_resp_err   = i_in.handshakes[HS_RESP_ERR];

    // Address stepper
    assign w_ctl.kind       = r_burst_kind;
    assign w_ctl.wrap_mask  = r_wrap_mask;
    assign w_ctl.beat_bytes = r_beat_bytes;

    asbrb_beat_addr #(
        .ADDR_BITS (ADDR_BITS)
    ) u_beat_addr (
        .i_addr (r_beat_addr),
        .i_ctl  (w_ctl),
        .o_next (w_next_addr)
    );

    // AXI channel readies from the current state
    always_comb begin
        w_aw_ready = 1'b0;
        w_w_ready  = 1'b0;
        w_ar_ready = 1'b0;
        w_b_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_aw_ready = 1'b1;
                w_w_ready  = 1'b1;
                w_ar_ready = !w_aw_valid;
            end
            ST_W:       w_w_ready = 1'b1;
            ST_BURST_W: w_w_ready = w_resp_valid;
            ST_B:       w_b_valid = 1'b1;
            default: begin
                w_aw_ready = 1'b0;
            end
        endcase
    end

    // Assemble the flag word
    always_comb begin
        w_flags               = '0;
        w_flags[FL_REQ_VALID] = r_dn_valid;
        w_flags[FL_REQ_WRITE] = r_dn_write;
        w_flags[FL_REQ_LAST]  = (r_beats_left == 8'd0);
        w_flags[FL_AW_READY]  = w_aw_ready;
        w_flags[FL_W_READY]   = w_w_ready;
        w_flags[FL_AR_READY]  = w_ar_ready;
        w_flags[FL_B_VALID]   = w_b_valid;
        w_flags[FL_R_VALID]   = r_rvalid;
        w_flags[FL_R_LAST]    = r_rlast;
        w_flags[FL_RESP_ERR]  = r_err;
    end

    // Next controller state and burst registers
    always_comb begin
        n_state      = r_state;
        n_dn_valid   = r_dn_valid;
        n_dn_write   = r_dn_write;
        n_beat_addr  = r_beat_addr;
        n_wdata      = r_wdata;
        n_wstrb      = r_wstrb;
        n_beat_bytes = r_beat_bytes;
        n_beats_left = r_beats_left;
        n_burst_kind = r_burst_kind;
        n_wrap_mask  = r_wrap_mask;
        n_id         = r_id;
        n_user       = r_user;
        n_rvalid     = r_rvalid;
        n_rlast      = r_rlast;
        n_rdata      = r_rdata;
        n_err        = r_err;
        unique case (r_state)
            ST_IDLE: begin
                n_dn_valid = 1'b0;
                n_dn_write = 1'b0;
                n_rvalid   = 1'b0;
                n_rlast    = 1'b0;
                n_err      = 1'b0;
                if (w_aw_valid || w_ar_valid) begin
                    n_beat_addr  = i_in.ax_address;
                    n_beat_bytes = 8'd1 << i_in.ax_size;
                    n_beats_left = i_in.ax_length;
                    n_burst_kind = i_in.ax_burst;
                    n_wrap_mask  = wrap_mask_of(i_in.ax_size, i_in.ax_length);
                    n_id         = i_in.ax_ident;
                    n_user       = i_in.ax_userbits;
                end
                priority if (w_aw_valid) begin
                    n_wdata = i_in.write_data;
                    n_wstrb = i_in.write_strobe;
                    if (w_w_valid) begin
                        n_dn_valid = 1'b1;
                        n_dn_write = 1'b1;
                        n_state = (i_in.ax_length != 8'd0) ? ST_BURST_W : ST_LAST_W;
                    end else begin
                        n_state = ST_W;
                    end
                end else if (w_ar_valid) begin
                    n_dn_valid = 1'b1;
                    n_state    = ST_ADDR_R;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_W: begin
                n_wdata = i_in.write_data;
                n_wstrb = i_in.write_strobe;
                if (w_w_valid) begin
                    n_dn_valid = 1'b1;
                    n_dn_write = 1'b1;
                    n_state = (r_beats_left != 8'd0) ? ST_BURST_W : ST_LAST_W;
                end
            end
            ST_BURST_W: begin
                n_dn_valid = w_w_valid;
                if (w_w_valid && w_resp_valid) begin
                    n_beat_addr = w_next_addr;
                    n_wdata     = i_in.write_data;
                    n_wstrb     = i_in.write_strobe;
                    if (r_beats_left == 8'd1) begin
                        n_state = ST_LAST_W;
                    end
                    if (r_beats_left != 8'd0) begin
                        n_beats_left = r_beats_left - 8'd1;
                    end
                end
            end
            ST_LAST_W: begin
                if (w_resp_valid) begin
                    n_dn_valid = 1'b0;
                    n_dn_write = 1'b0;
                    n_err      = w_resp_err;
                    n_state    = ST_B;
                end
            end
            ST_B: begin
                if (w_b_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADDR_R: begin
                if (w_req_ready) begin
                    if (r_beats_left != 8'd0) begin
                        n_beat_addr  = w_next_addr;
                        n_beats_left = r_beats_left - 8'd1;
                        n_state      = ST_ADDRDATA_R;
                    end else begin
                        n_dn_valid = 1'b0;
                        n_state    = ST_DATA_R;
                    end
                end
            end
            ST_ADDRDATA_R: begin
                n_rvalid = w_resp_valid;
                n_rdata  = i_in.read_data_in;
                n_err    = w_resp_err;
                priority if (!w_resp_valid || r_beats_left == 8'd0) begin
                    n_dn_valid = 1'b0;
                    n_state    = ST_DATA_R;
                end else if (!w_r_ready) begin
                    n_dn_valid = 1'b0;
                    n_state    = ST_OUT_R;
                end else if (!w_req_ready) begin
                    n_state = ST_ADDR_R;
                end else begin
                    n_beat_addr  = w_next_addr;
                    n_beats_left = r_beats_left - 8'd1;
                end
            end
            ST_DATA_R: begin
                if (w_resp_valid) begin
                    n_rvalid = 1'b1;
                    n_rdata  = i_in.read_data_in;
                    n_err    = w_resp_err;
                    n_rlast  = (r_beats_left == 8'd0);
                    n_state  = ST_OUT_R;
                end
            end
            ST_OUT_R: begin
                if (w_r_ready) begin
                    n_rvalid = 1'b0;
                    n_rlast  = 1'b0;
                    if (r_beats_left != 8'd0) begin
                        n_dn_valid = 1'b1;
                        n_state    = ST_ADDR_R;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // Advance the controller once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_dn_valid   <= 1'b0;
            r_dn_write   <= 1'b0;
            r_beat_addr  <= '0;
            r_wdata      <= '0;
            r_wstrb      <= '0;
            r_beat_bytes <= '0;
            r_beats_left <= '0;
            r_burst_kind <= '0;
            r_wrap_mask  <= '0;
            r_id         <= '0;
            r_user       <= '0;
            r_rvalid     <= 1'b0;
            r_rlast      <= 1'b0;
            r_rdata      <= '0;
            r_err        <= 1'b0;
        end else if (w_accept) begin
            r_state      <= n_state;
            r_dn_valid   <= n_dn_valid;
            r_dn_write   <= n_dn_write;
            r_beat_addr  <= n_beat_addr;
            r_wdata      <= n_wdata;
            r_wstrb      <= n_wstrb;
            r_beat_bytes <= n_beat_bytes;
            r_beats_left <= n_beats_left;
            r_burst_kind <= n_burst_kind;
            r_wrap_mask  <= n_wrap_mask;
            r_id         <= n_id;
            r_user       <= n_user;
            r_rvalid     <= n_rvalid;
            r_rlast      <= n_rlast;
            r_rdata      <= n_rdata;
            r_err        <= n_err;
        end
    end

    // Result valid: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: the outputs of the cycle just accepted
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_flags <= w_flags;
            r_out_addr  <= r_beat_addr;
            r_out_size  <= r_beat_bytes;
            r_out_wdata <= r_wdata;
            r_out_wstrb <= r_wstrb;
            r_out_rdata <= r_rdata;
            r_out_id    <= r_id;
            r_out_user  <= r_user;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.flags           = r_out_flags;
    assign o_out.request_address = r_out_addr;
    assign o_out.request_size    = r_out_size;
    assign o_out.request_wdata   = r_out_wdata;
    assign o_out.request_wstrb   = r_out_wstrb;
    assign o_out.read_data_out   = r_out_rdata;
    assign o_out.resp_ident      = r_out_id;
    assign o_out.resp_userbits   = r_out_user;

endmodule

// ===== rtl/asbrb_checker.sv =====
// ---------------------------------------------------------------------------
// asbrb_checker
// Port-level checks of the bridge's request and result channels.
// ---------------------------------------------------------------------------
`include "axi4_slave_burst_request_bridge_macros.svh"

module asbrb_checker
    import asbrb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [FLAG_BITS-1:0] i_out_flags
);

    // A stalled result holds its flags
    `ASBRB_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_flags),
        "result changed while stalled")

    // Every accepted request shows a result in the next cycle
    `ASBRB_ASSERT(a_in_to_out, i_clk, i_rst_n,
        i_in_valid && i_in_ready |=> i_out_valid,
        "accepted request gave no result")

    // An empty result register never stalls requests
    `ASBRB_ASSERT(a_no_idle_stall, i_clk, i_rst_n,
        !i_out_valid |-> i_in_ready,
        "request stalled with empty result register")

    // Reset clears the result valid
    `ASBRB_ASSERT_ALWAYS(a_reset_clear, i_clk,
        !i_rst_n |=> !i_out_valid,
        "result valid after reset")

endmodule

bind axi4_slave_burst_request_bridge asbrb_checker u_asbrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_flags (o_out.flags)
);
